@@ rtl/rotated_sorted_array_search_assert.svh @@
// Assertion macros for the rotated sorted array search block.
// RSAS_ASSERT checks a property on every rising clock edge outside reset.
// RSAS_ASSERT_ALWAYS checks a property on every rising clock edge, reset included.
`ifndef ROTATED_SORTED_ARRAY_SEARCH_ASSERT_SVH
`define ROTATED_SORTED_ARRAY_SEARCH_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RSAS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rsas assertion failed");
`define RSAS_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("rsas assertion failed");
`else
`define RSAS_ASSERT(lbl, prop)
`define RSAS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ rtl/rsas_pkg.sv @@
`default_nettype none
package rsas_pkg;

	localparam int DEF_MAX_ELEMENTS = 1024;
	localparam int COUNT_W = 11;
	localparam int VALUE_W = 32;
	localparam int POS_W = 10;

	// Register indexes of the configuration port.
	localparam logic REG_ELEMENT_COUNT = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PV_A,
		ST_PV_B,
		ST_PV_C,
		ST_CK_A,
		ST_CK_B,
		ST_BS_A,
		ST_BS_B,
		ST_DONE
	} rsas_state_t;

endpackage
`default_nettype wire

@@ rtl/rotated_sorted_array_search.sv @@
`default_nettype none
// Channel   Direction  Beat content
// s_*       in         tuser: mode; tdata: write_index, element_value, search_key
// m_*       out        tuser: found; tdata: found_position
// APB       in/out     register 0 (byte address 0): element_count
//
// A load beat is written to the element memory at the edge that accepts it.
// A search beat runs a pivot bisection, a pivot check and then a key bisection:
// each pivot bisection step needs four element reads through the two read ports
// of the element memory (states PV_A, PV_B, PV_C), each key bisection step one
// read (states BS_A, BS_B).
// Reset clears the sequencer, the output register and element_count; the element
// memory is not cleared. A stalled result waits in the output register while the
// next beat is accepted and processed; only the final handoff waits for it.
module rotated_sorted_array_search #(
	parameter int MAX_ELEMENTS = rsas_pkg::DEF_MAX_ELEMENTS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,  // [9:0] write_index, [41:10] element_value,
	                                   // [73:42] search_key, [79:74] zero
	input  wire logic        s_tuser,  // [0] mode: 0 load, 1 search
	// Result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // [9:0] found_position, [15:10] zero
	output logic             m_tuser,  // [0] found
	// Configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import rsas_pkg::*;

	`include "rotated_sorted_array_search_assert.svh"

	localparam int AW = $clog2(MAX_ELEMENTS);
	// Signed index width: holds -1 and MAX_ELEMENTS.
	localparam int IW = AW + 2;

	rsas_state_t state_q, state_d;

	logic [COUNT_W-1:0] element_count_q;

	logic signed [IW-1:0] lo_q, hi_q, mid_q, piv_q, n_q;
	logic signed [VALUE_W-1:0] key_q, dmid_q, dnext_q;
	logic res_found_q;
	logic [AW-1:0] res_idx_q;

	logic out_valid_q, out_found_q;
	logic [AW-1:0] out_idx_q;

	// Element memory: one write port, two read ports with registered data.
	logic signed [VALUE_W-1:0] mem [MAX_ELEMENTS];
	logic signed [VALUE_W-1:0] rd_a, rd_b;
	logic [AW-1:0] ra_a, ra_b, wa;
	logic mem_we;

	logic s_acc, cfg_wr;
	logic [31:0] wi32, n32, n_c, pos32;
	logic signed [IW-1:0] diff_c, mid_c;

	assign s_acc  = s_tvalid && s_tready;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_ELEMENT_COUNT) begin
			prdata = {{(32-COUNT_W){1'b0}}, element_count_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= '0;
		end else if (cfg_wr && paddr[2] == REG_ELEMENT_COUNT) begin
			element_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	// A count beyond the memory depth acts as a full memory.
	assign n32 = 32'(element_count_q);
	assign n_c = (n32 > 32'(MAX_ELEMENTS)) ? 32'(MAX_ELEMENTS) : n32;

	assign wi32 = 32'(s_tdata[9:0]);
	assign wa   = wi32[AW-1:0];

	// Midpoint of the current range; only used while lo <= hi, so diff is not negative.
	assign diff_c = hi_q - lo_q;
	assign mid_c  = lo_q + (diff_c >>> 1);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wa] <= s_tdata[41:10];
		end
		rd_a <= mem[ra_a];
		rd_b <= mem[ra_b];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc && s_tuser) begin
					state_d = ST_PV_A;
				end
			end
			ST_PV_A: begin
				priority if (lo_q > hi_q) begin
					state_d = ST_BS_A;
				end else if (lo_q == hi_q) begin
					state_d = ST_CK_A;
				end else begin
					state_d = ST_PV_B;
				end
			end
			ST_PV_B: state_d = ST_PV_C;
			ST_PV_C: begin
				priority if (mid_q < hi_q && dmid_q > dnext_q) begin
					state_d = ST_CK_A;
				end else if (mid_q > lo_q && dmid_q < rd_a) begin
					state_d = ST_CK_A;
				end else begin
					state_d = ST_PV_A;
				end
			end
			ST_CK_A: state_d = ST_CK_B;
			ST_CK_B: begin
				if (rd_a == key_q) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_BS_A;
				end
			end
			ST_BS_A: begin
				if (lo_q > hi_q) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_BS_B;
				end
			end
			ST_BS_B: begin
				if (rd_a == key_q) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_BS_A;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake and memory addresses.
	always_comb begin
		s_tready = 1'b0;
		mem_we   = 1'b0;
		ra_a     = mid_c[AW-1:0];
		ra_b     = lo_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				mem_we   = s_tvalid && !s_tuser && (wi32 < 32'(MAX_ELEMENTS));
			end
			ST_PV_A: begin
				ra_a = mid_c[AW-1:0];
				ra_b = AW'(mid_c + IW'(1));
			end
			ST_PV_B: begin
				ra_a = AW'(mid_q - IW'(1));
				ra_b = lo_q[AW-1:0];
			end
			ST_CK_A: begin
				ra_a = piv_q[AW-1:0];
				ra_b = '0;
			end
			ST_BS_A: begin
				ra_a = mid_c[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Search datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc && s_tuser) begin
					key_q       <= s_tdata[73:42];
					n_q         <= IW'(n_c);
					lo_q        <= '0;
					hi_q        <= IW'(n_c) - IW'(1);
					res_found_q <= 1'b0;
					res_idx_q   <= '0;
				end
			end
			ST_PV_A: begin
				mid_q <= mid_c;
				priority if (lo_q > hi_q) begin
					// Not rotated: bisect the whole array.
					lo_q <= '0;
					hi_q <= n_q - IW'(1);
				end else if (lo_q == hi_q) begin
					piv_q <= lo_q;
				end
			end
			ST_PV_B: begin
				dmid_q  <= rd_a;
				dnext_q <= rd_b;
			end
			ST_PV_C: begin
				priority if (mid_q < hi_q && dmid_q > dnext_q) begin
					piv_q <= mid_q;
				end else if (mid_q > lo_q && dmid_q < rd_a) begin
					piv_q <= mid_q - IW'(1);
				end else if (rd_b >= dmid_q) begin
					hi_q <= mid_q - IW'(1);
				end else begin
					lo_q <= mid_q + IW'(1);
				end
			end
			ST_CK_B: begin
				priority if (rd_a == key_q) begin
					res_found_q <= 1'b1;
					res_idx_q   <= piv_q[AW-1:0];
				end else if (rd_b <= key_q) begin
					lo_q <= '0;
					hi_q <= piv_q - IW'(1);
				end else begin
					lo_q <= piv_q + IW'(1);
					hi_q <= n_q - IW'(1);
				end
			end
			ST_BS_A: begin
				mid_q <= mid_c;
			end
			ST_BS_B: begin
				priority if (rd_a == key_q) begin
					res_found_q <= 1'b1;
					res_idx_q   <= mid_q[AW-1:0];
				end else if (key_q > rd_a) begin
					lo_q <= mid_q + IW'(1);
				end else begin
					hi_q <= mid_q - IW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: the finished result moves here once the previous one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
			out_found_q <= res_found_q;
			out_idx_q   <= res_idx_q;
		end
	end

	assign pos32    = 32'(out_idx_q);
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = {6'b0, pos32[POS_W-1:0]};

	`RSAS_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
	`RSAS_ASSERT(a_pivot_mid_inside, state_q == ST_PV_B |-> (mid_q >= lo_q && mid_q < hi_q))
	`RSAS_ASSERT(a_bisect_mid_inside, state_q == ST_BS_B |-> (mid_q >= lo_q && mid_q <= hi_q))
	`RSAS_ASSERT(a_found_below_count,
		(state_q == ST_DONE && res_found_q) |-> (IW'(res_idx_q) < n_q))
	`RSAS_ASSERT_ALWAYS(a_no_write_in_search, mem_we |-> state_q == ST_IDLE)

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rsas_pkg::*;

	// Beat kinds carried in s_tuser.
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	// Register index past the end of the register map; writes there must do nothing.
	localparam int REG_SPARE = 1;

	localparam int CAPACITY = DEF_MAX_ELEMENTS;
	localparam int LOWEST   = 32'sh8000_0000;
	localparam int HIGHEST  = 32'sh7fff_ffff;

	// Quiet time that a settling drain gives any beat still inside the block to settle.
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 5000;
	localparam int SEARCH_TARGET = 150;
	localparam int MIN_PHASES    = 6;

	// Shapes of the array contents loaded for a phase.
	localparam int KIND_ROTATED = 0;
	localparam int KIND_DENSE   = 1;
	localparam int KIND_PLAIN   = 2;
	localparam int KIND_JUMBLED = 3;

	typedef logic signed [VALUE_W-1:0] element_t;

	typedef struct packed {
		element_t         key;
		logic             found;
		logic [POS_W-1:0] position;
	} answer_t;

	// Mirrors the element memory and the count register, works out the answer of
	// every accepted search and checks the answers coming out of the block in order.
	class search_scoreboard;
		element_t           mirror [CAPACITY];
		logic [COUNT_W-1:0] element_count;
		answer_t            answers_due [$];
		int                 mismatches;

		function new();
			foreach (mirror[i]) mirror[i] = '0;
			element_count = '0;
			mismatches = 0;
		endfunction

		function void report(string text);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", text);
		endfunction

		// Plain bisection of an ascending range; -1 when the key is absent.
		function int bisect(int lo, int hi, element_t key);
			int mid;
			while (lo <= hi) begin
				mid = lo + (hi - lo) / 2;
				if (key == mirror[mid])
					return mid;
				if (key > mirror[mid])
					lo = mid + 1;
				else
					hi = mid - 1;
			end
			return -1;
		endfunction

		// Index of the largest element of a rotated range; -1 when none is found.
		function int find_peak(int lo, int hi);
			int mid;
			while (lo <= hi) begin
				if (hi == lo)
					return lo;
				mid = lo + (hi - lo) / 2;
				if (mid < hi && mirror[mid] > mirror[mid + 1])
					return mid;
				if (mid > lo && mirror[mid] < mirror[mid - 1])
					return mid - 1;
				if (mirror[lo] >= mirror[mid])
					hi = mid - 1;
				else
					lo = mid + 1;
			end
			return -1;
		endfunction

		function answer_t locate(element_t key);
			int n, peak, hit;
			answer_t answer;
			n = (element_count > CAPACITY) ? CAPACITY : int'(element_count);
			peak = find_peak(0, n - 1);
			if (peak < 0)
				hit = bisect(0, n - 1, key);
			else if (mirror[peak] == key)
				hit = peak;
			else if (mirror[0] <= key)
				hit = bisect(0, peak - 1, key);
			else
				hit = bisect(peak + 1, n - 1, key);
			answer.key = key;
			answer.found = (hit >= 0);
			answer.position = (hit >= 0) ? hit[POS_W-1:0] : '0;
			return answer;
		endfunction

		function void note_beat(logic mode, logic [POS_W-1:0] index, element_t value,
				element_t key);
			if (mode == MODE_LOAD)
				mirror[index] = value;
			else
				answers_due.push_back(locate(key));
		endfunction

		function void check_result(logic found, logic [POS_W-1:0] position);
			answer_t want;
			if (answers_due.size() == 0) begin
				report($sformatf("tb_top: result found=%0b position=%0d with no search pending",
					found, position));
				return;
			end
			want = answers_due.pop_front();
			if (found !== want.found)
				report($sformatf("tb_top: key %0d found flag: expected %0b, got %0b",
					want.key, want.found, found));
			if (position !== want.position)
				report($sformatf("tb_top: key %0d position: expected %0d, got %0d",
					want.key, want.position, position));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;   // [9:0] write_index, [41:10] element_value, [73:42] search_key
	logic        s_tuser;   // [0] mode
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [9:0] found_position
	logic        m_tuser;   // [0] found
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Idling knobs, set per phase by the stimulus and read by both stream sides.
	int   send_idle_pct;
	int   stall_pct;
	// Raised once by the stimulus; the result side then holds off on its own count.
	logic hold_req;
	int   quiet_cycles = 0;

	search_scoreboard sb = new();

	rotated_sorted_array_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Both streams are sampled at the rising edge, before any of this edge's
	// nonblocking updates land, so each beat is seen exactly once. The same block
	// runs the watchdog: it counts edges at which neither stream nor the register
	// port moved anything and gives up when that count gets out of hand.
	always @(posedge clk) begin
		logic s_fire, m_fire;
		s_fire = arst_n && s_tvalid && s_tready;
		m_fire = arst_n && m_tvalid && m_tready;
		if (s_fire)
			sb.note_beat(s_tuser, s_tdata[9:0], s_tdata[41:10], s_tdata[73:42]);
		if (m_fire)
			sb.check_result(m_tuser, m_tdata[POS_W-1:0]);
		if (s_fire || m_fire || (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// Result side. Normally it stalls at random at the phase's rate; once per run
	// it holds tready low for a long stretch so that the block backs up into its
	// input while the stimulus keeps offering searches.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req <= 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else
				m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offers one beat and returns at the edge that accepts it. tvalid stays high
	// into the next call unless that call decides to idle first.
	task automatic send_beat(input logic mode, input int index, input int value,
			input int key);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {6'b0, 32'(key), 32'(value), 10'(index)};
		do @(posedge clk); while (!s_tready);
	endtask

	// The index and value fields are don't-care in a search, so they carry noise.
	task automatic send_search(input int key);
		send_beat(MODE_SEARCH, $urandom_range(CAPACITY - 1), $urandom, key);
	endtask

	// Stops offering beats and waits for every pending answer; with settle set it
	// also lets any load or search still inside the block finish, so that the
	// block is idle for a register write.
	task automatic drain(input bit settle);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.answers_due.size() != 0);
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input int index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * index);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (index == REG_ELEMENT_COUNT)
			sb.element_count = value[COUNT_W-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_count_reg();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 3'(4 * REG_ELEMENT_COUNT);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(sb.element_count))
			sb.report($sformatf("tb_top: element_count read: expected %0d, got %0d",
				sb.element_count, prdata));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Only the low bits hold the count, so the upper write data bits are noise.
	task automatic apply_count(input int setting);
		reg_write(REG_ELEMENT_COUNT, ($urandom & ~32'h7ff) | 32'(setting));
		check_count_reg();
	endtask

	// Writes entries 0..n-1 in random order with the chosen shape: an ascending
	// array rotated by a random amount (spread over the whole range or densely
	// packed), one left unrotated, or small values with repeats in no order.
	task automatic load_array(input int n, input int kind);
		int sorted [$];
		int order [$];
		int shift, start;
		bit clash;
		if (n == 0)
			return;
		case (kind)
			KIND_JUMBLED: begin
				for (int i = 0; i < n; i++)
					sorted.push_back(int'($urandom_range(7)) - 4);
			end
			KIND_DENSE: begin
				start = int'($urandom) >>> 1;
				for (int i = 0; i < n; i++) begin
					sorted.push_back(start);
					start += int'($urandom_range(1, 3));
				end
			end
			default: begin
				do begin
					sorted.delete();
					for (int i = 0; i < n; i++)
						sorted.push_back(int'($urandom));
					if (n >= 2 && $urandom_range(2) == 0) begin
						sorted[0] = LOWEST;
						sorted[n - 1] = HIGHEST;
					end
					sorted.sort();
					clash = 1'b0;
					for (int i = 1; i < n; i++)
						if (sorted[i] == sorted[i - 1])
							clash = 1'b1;
				end while (clash);
			end
		endcase
		shift = (kind == KIND_ROTATED || kind == KIND_DENSE) ? $urandom_range(n - 1) : 0;
		for (int i = 0; i < n; i++)
			order.push_back(i);
		order.shuffle();
		foreach (order[k])
			send_beat(MODE_LOAD, order[k], sorted[(order[k] + shift) % n], $urandom);
	endtask

	// Keys are mostly stored elements or their neighbors, so that hits and
	// near misses dominate; the rest are range extremes, zero and random values.
	function automatic int pick_key(input int n);
		int roll;
		roll = $urandom_range(99);
		if (n > 0 && roll < 60)
			return sb.mirror[$urandom_range(n - 1)];
		if (n > 0 && roll < 75)
			return sb.mirror[$urandom_range(n - 1)] + ($urandom_range(1) ? 1 : -1);
		if (roll < 85) begin
			case ($urandom_range(2))
				0: return LOWEST;
				1: return HIGHEST;
				default: return 0;
			endcase
		end
		return $urandom;
	endfunction

	initial begin
		int phase, searches, n, kind, roll, rounds;
		int settings [$];

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= MODE_LOAD;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		hold_req <= 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The count is zero after reset, so both searches must miss.
		send_search(0);
		send_search(LOWEST);

		// Five elements, ascending and rotated, with both range extremes in them
		// and the peak at index 1. The top index gets a pattern of its own.
		send_beat(MODE_LOAD, 0, 10, $urandom);
		send_beat(MODE_LOAD, 1, HIGHEST, $urandom);
		send_beat(MODE_LOAD, 2, LOWEST, $urandom);
		send_beat(MODE_LOAD, 3, -5, $urandom);
		send_beat(MODE_LOAD, 4, 3, $urandom);
		send_beat(MODE_LOAD, CAPACITY - 1, 32'h5555_5555, $urandom);
		drain(1);
		reg_write(REG_ELEMENT_COUNT, 32'hffff_f805);
		check_count_reg();

		// Left half, the peak itself, right half, and misses on either side.
		send_search(10);
		send_search(HIGHEST);
		send_search(LOWEST);
		send_search(3);
		send_search(4);
		send_search(-6);

		// A single element: the peak search stops at once.
		drain(1);
		reg_write(REG_ELEMENT_COUNT, 1);
		check_count_reg();
		send_search(10);
		send_search(11);

		// A write past the register map must leave the count alone.
		drain(1);
		reg_write(REG_SPARE, 0);
		check_count_reg();
		send_search(10);

		// Random phases. Each one loads a fresh array, sets the count while the
		// block is idle and then runs searches with a sprinkling of stray loads.
		// The third phase fills the whole memory and runs with a count above the
		// capacity and then at the capacity; the sixth one runs on an empty array.
		phase = 0;
		searches = 0;
		while (searches < SEARCH_TARGET || phase < MIN_PHASES) begin
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 74;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 74;
				end
				default: begin
					send_idle_pct = 30;
					stall_pct = 30;
				end
			endcase

			settings.delete();
			if (phase == 2) begin
				n = CAPACITY;
				settings.push_back(2047);
				settings.push_back(CAPACITY);
			end else if (phase == 5) begin
				n = 0;
				settings.push_back(0);
			end else begin
				n = $urandom_range(1, 32);
				settings.push_back(n);
			end

			roll = $urandom_range(99);
			if (roll < 55)
				kind = KIND_ROTATED;
			else if (roll < 75)
				kind = KIND_DENSE;
			else if (roll < 85)
				kind = KIND_PLAIN;
			else
				kind = KIND_JUMBLED;
			load_array(n, kind);

			foreach (settings[s]) begin
				drain(1);
				apply_count(settings[s]);
				rounds = $urandom_range(15, 35);
				for (int j = 0; j < rounds; j++) begin
					// Back the block up once, in a phase where nothing idles.
					if (phase == 0 && j == 8)
						hold_req <= 1'b1;
					// Every third phase the sender stops until all answers are in.
					if (phase % 3 == 1 && j == rounds / 2)
						drain(0);
					// Stray loads land anywhere, breaking the order now and then.
					if ($urandom_range(19) == 0)
						send_beat(MODE_LOAD, $urandom_range(CAPACITY - 1), $urandom, $urandom);
					else begin
						send_search(pick_key(n));
						searches++;
					end
				end
			end
			phase++;
		end

		drain(1);
		if (sb.mismatches == 0 && sb.answers_due.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
